// ===== rtl/b2d_pkg.sv =====
`timescale 1ns / 1ps
package b2d_pkg;
	localparam int unsigned MaxWidthDef = 32;
	localparam int unsigned ValW = 64;
	localparam int unsigned ReqW = 6;
	localparam int unsigned CharW = 16;
	localparam int unsigned PosW = 6;
	localparam int unsigned NDig = 20;
	localparam int unsigned NDigW = 5;
	localparam int unsigned StgBits = 8;
	localparam int unsigned NStg = ValW / StgBits;
	localparam logic [CharW-1:0] DigitZero = 16'd48;
	localparam logic [CharW-1:0] PadReset = 16'd48;
	localparam logic [CharW-1:0] TrailerReset = 16'd0;

	typedef enum logic [0:0] {
		REG_PAD     = 1'b0,
		REG_TRAILER = 1'b1
	} reg_idx_t;

	typedef logic [NDig-1:0][3:0] bcd_t;

	typedef struct packed {
		bcd_t            bcd;
		logic [ValW-1:0] bin;
	} dabble_t;

	// eight double-dabble steps: adjust every digit, then shift in one bit
	function automatic dabble_t dabble8(input dabble_t d);
		dabble_t r;
		r = d;
		for (int s = 0; s < StgBits; s++) begin
			for (int i = 0; i < NDig; i++) begin
				if (r.bcd[i] >= 4'd5)
					r.bcd[i] = r.bcd[i] + 4'd3;
			end
			r = dabble_t'({r.bcd, r.bin} << 1);
		end
		return r;
	endfunction
endpackage

// ===== rtl/binary_to_decimal_padded_text_core.sv =====
`timescale 1ns / 1ps
// An accepted beat loads the first of 8 double-dabble stages, then passes through
// the digit count, emitter load and output registers to its first character beat.
// Output is one character beat per cycle while m_axis_tready holds; an item is one
// beat per pad or digit, plus a trailer beat if set. Input beats enter every cycle
// while the pipeline has room. Reset clears all valid bits and returns the config
// regs to their defaults.
module binary_to_decimal_padded_text_core
	import b2d_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // value[63:0], min_digits[69:64], zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_char[15:0], position[21:16], zero fill
	output logic [1:0]  m_axis_tuser,   // unwritten[0], width_exceeded[1]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int unsigned CW = $clog2(MAX_WIDTH + 2);
	localparam logic [CW-1:0] MaxReq = CW'(MAX_WIDTH);

	logic [CharW-1:0] pad_q, trailer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q     <= PadReset;
			trailer_q <= TrailerReset;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PAD:     pad_q     <= cfg_data;
				REG_TRAILER: trailer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// conversion pipeline
	logic           valid_s [NStg];
	dabble_t        dab_s   [NStg];
	logic [CW-1:0]  req_s   [NStg];
	logic           rdy     [NStg+1];

	logic           valid_s9;
	bcd_t           bcd_s9;
	logic [NDigW-1:0] ndig_s9;
	logic [CW-1:0]  req_s9;

	logic           em_ready;
	logic [ReqW-1:0] min_in;
	logic [CW-1:0]  req_in;

	assign min_in = s_axis_tdata[ValW +: ReqW];
	assign req_in = ({1'b0, min_in} > {1'b0, CW'(MAX_WIDTH)} ) ? MaxReq : CW'(min_in);

	assign rdy[NStg]     = !valid_s9 || em_ready;
	assign s_axis_tready = rdy[0];

	for (genvar k = 0; k < NStg; k++) begin : g_stg
		assign rdy[k] = !valid_s[k] || rdy[k+1];
		if (k == 0) begin : g_first
			dabble_t din;
			assign din.bcd = '0;
			assign din.bin = s_axis_tdata[ValW-1:0];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					valid_s[k] <= 1'b0;
				else if (rdy[k])
					valid_s[k] <= s_axis_tvalid;
			end
			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					dab_s[k] <= dabble8(din);
					req_s[k] <= req_in;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					valid_s[k] <= 1'b0;
				else if (rdy[k])
					valid_s[k] <= valid_s[k-1];
			end
			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					dab_s[k] <= dabble8(dab_s[k-1]);
					req_s[k] <= req_s[k-1];
				end
			end
		end
	end

	// digit count from the highest nonzero digit
	logic [NDigW-1:0] ndig_c;
	always_comb begin
		ndig_c = NDigW'(1);
		for (int i = 0; i < NDig; i++) begin
			if (dab_s[NStg-1].bcd[i] != 4'd0)
				ndig_c = NDigW'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s9 <= 1'b0;
		else if (rdy[NStg])
			valid_s9 <= valid_s[NStg-1];
	end

	always_ff @(posedge clk) begin
		if (rdy[NStg]) begin
			bcd_s9  <= dab_s[NStg-1].bcd;
			ndig_s9 <= ndig_c;
			req_s9  <= req_s[NStg-1];
		end
	end

	// character emitter
	logic          active_q, exc_q;
	bcd_t          bcd_q;
	logic [CW-1:0] width_q, npad_q, k_q;
	logic [CW-1:0] total_c, didx_c, ndig_ext, width_c;
	logic          last_c, out_load;
	logic [3:0]    nib_c;

	logic             o_valid_q, o_unwr_q, o_exc_q, o_last_q;
	logic [CharW-1:0] o_char_q;
	logic [PosW-1:0]  o_pos_q;

	assign ndig_ext = CW'(ndig_s9);
	assign width_c  = (req_s9 > ndig_ext) ? req_s9 : ndig_ext;
	assign total_c  = width_q + CW'(trailer_q != '0);
	assign last_c   = (k_q + CW'(1)) == total_c;
	assign out_load = active_q && (!o_valid_q || m_axis_tready);
	assign em_ready = !active_q || (out_load && last_c);
	assign didx_c   = width_q - CW'(1) - k_q;
	assign nib_c    = (didx_c < CW'(NDig)) ? bcd_q[didx_c[NDigW-1:0]] : 4'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (em_ready)
				active_q <= valid_s9;
			else if (out_load && last_c)
				active_q <= 1'b0;
			if (out_load)
				o_valid_q <= 1'b1;
			else if (m_axis_tready)
				o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em_ready && valid_s9) begin
			bcd_q   <= bcd_s9;
			width_q <= width_c;
			npad_q  <= width_c - ndig_ext;
			exc_q   <= ndig_ext > req_s9;
			k_q     <= '0;
		end else if (out_load) begin
			k_q <= k_q + CW'(1);
		end
		if (out_load) begin
			o_pos_q  <= PosW'(k_q);
			o_exc_q  <= exc_q;
			o_last_q <= last_c;
			if (k_q < npad_q) begin
				o_char_q <= pad_q;
				o_unwr_q <= pad_q == '0;
			end else if (k_q < width_q) begin
				o_char_q <= DigitZero + CharW'(nib_c);
				o_unwr_q <= 1'b0;
			end else begin
				o_char_q <= trailer_q;
				o_unwr_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata  = {2'b00, o_pos_q, o_char_q};
	assign m_axis_tuser  = {o_exc_q, o_unwr_q};
	assign m_axis_tlast  = o_last_q;

	a_count_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (k_q < total_c))
		else $error("emitter counter ran past the end of the run");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s[0])
		else $error("input stalled with an empty first stage");
	a_ndig_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s9 |-> (ndig_s9 != '0 && ndig_s9 <= NDigW'(NDig)))
		else $error("digit count out of range");
	a_unwr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && o_unwr_q) |-> (o_char_q == '0))
		else $error("unwritten beat carries a nonzero character");
endmodule

// ===== tb/sv/b2d_text_checker.sv =====
`timescale 1ns / 1ps
module b2d_text_checker
	import b2d_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
	input  logic        clk,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending_chars
);
	typedef struct packed {
		logic [CharW-1:0] ch;
		logic [PosW-1:0]  pos;
		logic             unwr;
		logic             exc;
		logic             lst;
	} text_char_t;

	text_char_t       char_q[$];
	logic [CharW-1:0] pad_reg = PadReset;
	logic [CharW-1:0] trail_reg = TrailerReset;

	assign pending_chars = char_q.size();

	initial fail_count = 0;

	task automatic format_value(input logic [63:0] value, input logic [5:0] req_in);
		logic [3:0] digs[20];
		int ndig;
		int req;
		int width;
		int npad;
		logic exc;
		text_char_t c;
		ndig = 0;
		do begin
			digs[ndig] = 4'(value % 10);
			value = value / 10;
			ndig++;
		end while (value != 0 && ndig < 20);
		req = (req_in > MAX_WIDTH) ? MAX_WIDTH : req_in;
		exc = ndig > req;
		width = (req > ndig) ? req : ndig;
		npad = width - ndig;
		for (int i = 0; i < width; i++) begin
			if (i < npad) begin
				c.ch = pad_reg;
				c.unwr = pad_reg == 0;
			end else begin
				c.ch = DigitZero + digs[ndig - 1 - (i - npad)];
				c.unwr = 1'b0;
			end
			c.pos = PosW'(i);
			c.exc = exc;
			c.lst = (i == width - 1) && trail_reg == 0;
			char_q.push_back(c);
		end
		if (trail_reg != 0) begin
			c = '{trail_reg, PosW'(width), 1'b0, exc, 1'b1};
			char_q.push_back(c);
		end
	endtask

	always @(posedge clk) begin
		text_char_t got;
		text_char_t want;
		if (cfg_we) begin
			if (reg_idx_t'(cfg_index) == REG_PAD)
				pad_reg <= cfg_data;
			else
				trail_reg <= cfg_data;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[15:0], m_axis_tdata[21:16], m_axis_tuser[0],
				m_axis_tuser[1], m_axis_tlast};
			if (char_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got %h", $time, got);
				fail_count++;
			end else begin
				want = char_q.pop_front();
				if (got.ch !== want.ch)
					$display("%0t: char expected %h got %h", $time, want.ch, got.ch);
				if (got.pos !== want.pos)
					$display("%0t: position expected %0d got %0d", $time, want.pos, got.pos);
				if (got.unwr !== want.unwr)
					$display("%0t: unwritten expected %b got %b", $time, want.unwr, got.unwr);
				if (got.exc !== want.exc)
					$display("%0t: exceeded expected %b got %b", $time, want.exc, got.exc);
				if (got.lst !== want.lst)
					$display("%0t: last expected %b got %b", $time, want.lst, got.lst);
				if (got !== want)
					fail_count++;
			end
		end
		// predict after the pop so a same-cycle beat never sees its own expectations
		if (s_axis_tvalid && s_axis_tready)
			format_value(s_axis_tdata[63:0], s_axis_tdata[69:64]);
	end
endmodule

// ===== tb/sv/binary_to_decimal_padded_text_core_tb.sv =====
`timescale 1ns / 1ps
module binary_to_decimal_padded_text_core_tb;
	import b2d_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          fail_count;
	int          pending_chars;
	int          cycle_count = 0;
	int          idle_pct = 20;

	always #1 clk = ~clk;

	binary_to_decimal_padded_text_core uut (.*);

	b2d_text_checker checker_i (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stalls at random
	always @(negedge clk)
		m_axis_tready <= arst_n && ($urandom_range(99) >= idle_pct);

	// tvalid stays high into the next item unless an idle cycle drops it
	task automatic send_value(input logic [63:0] value, input logic [5:0] req);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {2'b00, req, value};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		while (pending_chars != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		// spread digit counts from 1 to 20
		return v >> $urandom_range(63);
	endfunction

	initial begin
		logic [15:0] pads[4];
		logic [15:0] trails[4];
		pads = '{16'h0030, 16'h0000, 16'hFFFF, 16'h0020};
		trails = '{16'h0000, 16'hFFFF, 16'h0001, 16'h002C};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: reset registers, then pad zero with a trailer
		send_value(64'd0, 6'd0);
		send_value(64'd0, 6'd32);
		send_value(64'd7, 6'd63);
		send_value(64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
		send_value(64'hFFFF_FFFF_FFFF_FFFF, 6'd20);
		send_value(64'hFFFF_FFFF_FFFF_FFFF, 6'd33);
		send_value(64'd12345, 6'd5);
		send_value(64'd12345, 6'd4);
		send_value(64'd9999999999, 6'd21);
		drain_and_settle();
		write_reg(REG_PAD, 16'h0000);
		write_reg(REG_TRAILER, 16'hFFFF);
		send_value(64'd42, 6'd10);
		send_value(64'd0, 6'd1);
		send_value(64'h8000_0000_0000_0000, 6'd42);
		send_value(64'd10000000000000000000, 6'd19);
		send_value(64'd1, 6'd32);
		for (int phase = 0; phase < 4; phase++) begin
			drain_and_settle();
			write_reg(REG_PAD, pads[phase]);
			write_reg(REG_TRAILER, trails[phase]);
			idle_pct = (phase == 2) ? 0 : 20;
			for (int n = 0; n < 52; n++)
				send_value(rand_value(), 6'($urandom_range(63)));
		end
		drain_and_settle();
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
